/* design/psp_pkg.sv */
// Shared types and constants for the positional speed PID block.
// No dependencies; imported by every module of the block but psp_checker.
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

    // field and datapath widths
    localparam int DELTA_W  = 16;
    localparam int SPEED_W  = 16;
    localparam int SCALE_W  = 24;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 31;
    localparam int DRIVE_W  = 32;
    localparam int ERR_W    = 41;   // target - measured, Q.16
    localparam int DIFF_W   = 42;   // error - previous error
    localparam int MUL_A_W  = 42;
    localparam int MUL_B_W  = 25;
    localparam int PROD_W   = 64;
    localparam int INC_W    = 56;   // integral increment and unclamped sum
    localparam int INTEG_W  = 48;   // clamped integral, Q.16
    localparam int WHOLE_W  = PROD_W - 24;

    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    // the float controller scales every term by 100
    localparam logic signed [MUL_B_W-1:0] PID_FACTOR = MUL_B_W'(100);
    // rounding biases for truncation toward zero
    localparam logic signed [PROD_W-1:0]  INC_BIAS   = PROD_W'(255);
    localparam logic signed [PROD_W-1:0]  OUT_BIAS   = PROD_W'(16777215);
    localparam logic signed [WHOLE_W-1:0] DRIVE_MAX  = WHOLE_W'(64'sd2147483647);
    localparam logic signed [WHOLE_W-1:0] DRIVE_MIN  = -WHOLE_W'(64'sd2147483648);

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(2147483647);

    typedef enum logic [2:0] {
        REG_TARGET = 3'd0,
        REG_SCALE  = 3'd1,
        REG_GAIN_P = 3'd2,
        REG_GAIN_I = 3'd3,
        REG_GAIN_D = 3'd4,
        REG_LIMIT  = 3'd5
    } psp_reg_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] target_speed;
        logic [SCALE_W-1:0]        count_scale;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic [LIMIT_W-1:0]        integral_limit;
    } psp_cfg_t;

endpackage

`default_nettype wire

/* design/psp_apb_regs.sv */
// APB register file for the speed PID: six setup registers.
// Depends on psp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psp_apb_regs
    import psp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready,
    output psp_cfg_t               cfg
);

    psp_cfg_t cfg_reg;
    psp_cfg_t cfg_next;
    logic     wr_en;
    psp_reg_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = psp_reg_t'(paddr[APB_AW-1:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_TARGET: cfg_next.target_speed   = $signed(pwdata[SPEED_W-1:0]);
                REG_SCALE:  cfg_next.count_scale    = pwdata[SCALE_W-1:0];
                REG_GAIN_P: cfg_next.gain_p         = $signed(pwdata[GAIN_W-1:0]);
                REG_GAIN_I: cfg_next.gain_i         = $signed(pwdata[GAIN_W-1:0]);
                REG_GAIN_D: cfg_next.gain_d         = $signed(pwdata[GAIN_W-1:0]);
                REG_LIMIT:  cfg_next.integral_limit = pwdata[LIMIT_W-1:0];
                default:    cfg_next = cfg_reg;     // unmapped: ignored
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_TARGET: prdata = APB_DW'(unsigned'(cfg_reg.target_speed));
            REG_SCALE:  prdata = APB_DW'(cfg_reg.count_scale);
            REG_GAIN_P: prdata = APB_DW'(unsigned'(cfg_reg.gain_p));
            REG_GAIN_I: prdata = APB_DW'(unsigned'(cfg_reg.gain_i));
            REG_GAIN_D: prdata = APB_DW'(unsigned'(cfg_reg.gain_d));
            REG_LIMIT:  prdata = APB_DW'(cfg_reg.integral_limit);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_speed   <= '0;
            cfg_reg.count_scale    <= SCALE_RESET;
            cfg_reg.gain_p         <= '0;
            cfg_reg.gain_i         <= '0;
            cfg_reg.gain_d         <= '0;
            cfg_reg.integral_limit <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* design/psp_mul.sv */
// Shared signed multiplier with registered product, used by every PID term.
// Depends on psp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psp_mul
    import psp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire logic signed [MUL_A_W-1:0] a,
    input  wire logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]       prod
);

    logic signed [MUL_A_W+MUL_B_W-1:0] full;
    logic signed [PROD_W-1:0]          prod_reg;

    // every product in use fits 64 bits signed
    assign full = a * b;
    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= $signed(full[PROD_W-1:0]);
        end
    end

endmodule

`default_nettype wire

/* design/positional_speed_pid.sv */
// Top level of the positional speed PID: sequencer, datapath registers,
// output register. Depends on psp_pkg, psp_apb_regs and psp_mul.
//
// Usage:
//   Input channel (in_valid / in_stall / encoder_delta): one beat per
//   control period, the signed encoder count since the previous period.
//   Output channel (out_valid / out_stall / drive_value): one beat per
//   input beat, the controller output saturated to 32 bits signed.
//   Setup goes through the APB port (six registers at 4*i); write it only
//   while no item is in flight.
// Timing:
//   After an input beat is taken the block runs a 13-step sequence on one
//   shared 42x25 multiplier; drive_value is valid once the sequence ends.
//   in_stall is high while the sequence runs, so a new item is taken only
//   once the last one has left the sequencer. The sequence length is set
//   by the seven dependent products on that multiplier plus the increment,
//   clamp, sum and rounding steps that follow them.
//   The result sits in an output register, so the next item is accepted
//   while a result still waits.
// Reset: clears the integral, the previous error and the output valid,
//   and loads the register reset values (unity count scale, zero gains,
//   widest integral clamp).
// Stall: if the last step finds the output register still full and
//   stalled, the sequencer holds there until the receiver takes the beat.
`timescale 1ns / 1ps
`default_nettype none

module positional_speed_pid
    import psp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // input channel
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [DELTA_W-1:0] encoder_delta,
    // output channel
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [DRIVE_W-1:0]      drive_value,
    // setup port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_AW-1:0]         paddr,
    input  wire logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]              prdata,
    output logic                           pready
);

    // one state per step of the shared multiplier / adder
    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAS,     // measured = delta * count_scale
        S_ERR,      // error; gain_p * 100
        S_P,        // error * kp100
        S_PD,       // acc = p; diff; gain_d * 100
        S_D,        // diff * kd100
        S_DI,       // acc += d; gain_i * 100
        S_I,        // error * ki100
        S_INC,      // increment = product / 256 toward zero
        S_ACCI,     // add old integral
        S_CLAMP,    // clamp to +/- limit
        S_SUM,      // acc += integral * 256
        S_RND,      // bias negative sums for truncation toward zero
        S_OUT       // saturate, load output register
    } state_t;

    psp_cfg_t cfg;

    state_t                      state_reg, state_next;
    logic signed [DELTA_W-1:0]   delta_reg, delta_next;
    logic signed [ERR_W-1:0]     err_reg, err_next;
    logic signed [ERR_W-1:0]     prev_reg, prev_next;
    logic signed [DIFF_W-1:0]    diff_reg, diff_next;
    logic signed [PROD_W-1:0]    acc_reg, acc_next;
    logic signed [INC_W-1:0]     tmp_reg, tmp_next;
    logic signed [INTEG_W-1:0]   integ_reg, integ_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [DRIVE_W-1:0]   out_data_reg, out_data_next;

    logic                        mul_en;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    prod;

    logic signed [PROD_W-1:0]    inc_full;
    logic signed [INC_W-1:0]     lim_pos;
    logic signed [INC_W-1:0]     lim_neg;
    logic signed [WHOLE_W-1:0]   whole;
    logic                        in_take;
    logic                        out_free;

    psp_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psp_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign in_take     = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign drive_value = out_data_reg;
    assign out_free    = !(out_valid_reg && out_stall);

    // truncation toward zero of product / 256
    assign inc_full = (prod + (prod[PROD_W-1] ? INC_BIAS : '0)) >>> 8;
    // clamp bound: limit in Q.16, never negative
    assign lim_pos  = INC_W'($signed({1'b0, cfg.integral_limit, 16'b0}));
    assign lim_neg  = -lim_pos;
    assign whole    = WHOLE_W'(acc_reg >>> 24);

    always_comb
    begin
        state_next     = state_reg;
        delta_next     = delta_reg;
        err_next       = err_reg;
        prev_next      = prev_reg;
        diff_next      = diff_reg;
        acc_next       = acc_reg;
        tmp_next       = tmp_reg;
        integ_next     = integ_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    delta_next = encoder_delta;
                    state_next = S_MEAS;
                end
            end
            S_MEAS:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(delta_reg);
                mul_b      = $signed({1'b0, cfg.count_scale});
                state_next = S_ERR;
            end
            S_ERR:
            begin
                err_next   = (ERR_W'(cfg.target_speed) <<< 16)
                             - $signed(prod[ERR_W-1:0]);
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(cfg.gain_p);
                mul_b      = PID_FACTOR;
                state_next = S_P;
            end
            S_P:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(err_reg);
                mul_b      = $signed(prod[MUL_B_W-1:0]);
                state_next = S_PD;
            end
            S_PD:
            begin
                acc_next   = prod;
                diff_next  = DIFF_W'(err_reg) - DIFF_W'(prev_reg);
                prev_next  = err_reg;
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(cfg.gain_d);
                mul_b      = PID_FACTOR;
                state_next = S_D;
            end
            S_D:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(diff_reg);
                mul_b      = $signed(prod[MUL_B_W-1:0]);
                state_next = S_DI;
            end
            S_DI:
            begin
                acc_next   = acc_reg + prod;
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(cfg.gain_i);
                mul_b      = PID_FACTOR;
                state_next = S_I;
            end
            S_I:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_W'(err_reg);
                mul_b      = $signed(prod[MUL_B_W-1:0]);
                state_next = S_INC;
            end
            S_INC:
            begin
                tmp_next   = INC_W'(inc_full);
                state_next = S_ACCI;
            end
            S_ACCI:
            begin
                tmp_next   = tmp_reg + INC_W'(integ_reg);
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (tmp_reg > lim_pos)
                begin
                    integ_next = INTEG_W'(lim_pos);
                end
                else if (tmp_reg < lim_neg)
                begin
                    integ_next = INTEG_W'(lim_neg);
                end
                else
                begin
                    integ_next = INTEG_W'(tmp_reg);
                end
                state_next = S_SUM;
            end
            S_SUM:
            begin
                acc_next   = acc_reg + (PROD_W'(integ_reg) <<< 8);
                state_next = S_RND;
            end
            S_RND:
            begin
                acc_next   = acc_reg + (acc_reg[PROD_W-1] ? OUT_BIAS : '0);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    if (whole > DRIVE_MAX)
                    begin
                        out_data_next = DRIVE_W'(DRIVE_MAX);
                    end
                    else if (whole < DRIVE_MIN)
                    begin
                        out_data_next = DRIVE_W'(DRIVE_MIN);
                    end
                    else
                    begin
                        out_data_next = DRIVE_W'(whole);
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            delta_reg     <= '0;
            err_reg       <= '0;
            prev_reg      <= '0;
            diff_reg      <= '0;
            acc_reg       <= '0;
            tmp_reg       <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            delta_reg     <= delta_next;
            err_reg       <= err_next;
            prev_reg      <= prev_next;
            diff_reg      <= diff_next;
            acc_reg       <= acc_next;
            tmp_reg       <= tmp_next;
            integ_reg     <= integ_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

`default_nettype wire

/* design/psp_checker.sv */
// Port-level checks for positional_speed_pid, bound to the top level.
// Depends on positional_speed_pid's ports only.
`timescale 1ns / 1ps
`default_nettype none

module psp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] drive_value
);

    // taking a beat starts a multi-cycle sequence
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a beat was taken");

    // the block only goes busy because it took a beat
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stall rose without a taken beat");

    // a new result appears only as the sequence ends
    a_result_ends_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $fell(in_stall))
        else $error("result appeared outside sequence end");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(drive_value)))
        else $error("stalled output beat changed");

endmodule

bind positional_speed_pid psp_checker u_psp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_value (drive_value)
);

`default_nettype wire

/* dv/tb_positional_speed_pid.sv */
// Self-checking testbench for positional_speed_pid: a queue-fed driver,
// a clocked monitor and a bit-exact fixed-point PID predictor.
// Depends on psp_pkg and the positional_speed_pid RTL.
`timescale 1ns / 1ps

module tb_positional_speed_pid;
    import psp_pkg::*;

    // register slots past the map; writes there must be dropped
    localparam int REG_SPARE_LO = 6;
    localparam int REG_SPARE_HI = 7;
    localparam int PHASES       = 11;
    localparam int PHASE_BEATS  = 100;
    localparam int SETTLE       = 20;   // margin past the end of the last sequence

    logic                        clk;
    logic                        rst_n         = 1'b0;
    logic                        in_valid      = 1'b0;
    logic                        in_stall;
    logic signed [DELTA_W-1:0]   encoder_delta = '0;
    logic                        out_valid;
    logic                        out_stall     = 1'b0;
    logic signed [DRIVE_W-1:0]   drive_value;
    logic                        psel          = 1'b0;
    logic                        penable       = 1'b0;
    logic                        pwrite        = 1'b0;
    logic [APB_AW-1:0]           paddr         = '0;
    logic [APB_DW-1:0]           pwdata        = '0;
    logic [APB_DW-1:0]           prdata;
    logic                        pready;

    // stimulus and scoreboard
    logic signed [DELTA_W-1:0]   pending_deltas[$];
    logic signed [DRIVE_W-1:0]   expected_drive[$];
    int                          deltas_in_flight = 0;
    int                          mismatches       = 0;
    int                          send_gap_pct     = 0;
    int                          recv_stall_pct   = 0;

    // predictor copy of the setup registers and the controller state
    psp_cfg_t                    cfg;
    logic signed [INTEG_W-1:0]   prev_err;
    logic signed [INTEG_W-1:0]   integ;

    positional_speed_pid dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .encoder_delta (encoder_delta),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .drive_value   (drive_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // One control period of the controller, all in 64-bit signed math.
    // Error and integral are Q.16, P and D terms Q.24; the integral
    // increment and the final shift both truncate toward zero.
    function automatic logic signed [DRIVE_W-1:0] step_controller(
        input logic signed [DELTA_W-1:0] delta);
        longint measured, err, p_term, d_term, i_inc, lim, acc, total, whole;
        measured = longint'(delta) * longint'({40'd0, cfg.count_scale});
        err      = longint'($signed(cfg.target_speed)) * 65536 - measured;
        p_term   = err * longint'($signed(cfg.gain_p)) * 100;
        d_term   = (err - longint'(prev_err)) * longint'($signed(cfg.gain_d)) * 100;
        i_inc    = (err * longint'($signed(cfg.gain_i)) * 100) / 256;
        lim      = longint'({33'd0, cfg.integral_limit}) * 65536;
        acc      = longint'(integ) + i_inc;
        // integral clamp; a zero limit pins it at zero
        if (acc > lim)
            acc = lim;
        else if (acc < -lim)
            acc = -lim;
        integ    = INTEG_W'(acc);
        prev_err = INTEG_W'(err);
        total    = p_term + d_term + acc * 256;
        whole    = total / 64'sd16777216;
        // integer part saturates at the 32-bit signed range
        if (whole > longint'(DRIVE_MAX))
            whole = longint'(DRIVE_MAX);
        else if (whole < longint'(DRIVE_MIN))
            whole = longint'(DRIVE_MIN);
        return DRIVE_W'(whole);
    endfunction

    // Mirror of a register write: oversized data keeps only the low bits,
    // unmapped slots change nothing.
    function automatic void shadow_reg(input int idx, input logic [APB_DW-1:0] data);
        case (idx)
            REG_TARGET: cfg.target_speed   = data[SPEED_W-1:0];
            REG_SCALE:  cfg.count_scale    = data[SCALE_W-1:0];
            REG_GAIN_P: cfg.gain_p         = data[GAIN_W-1:0];
            REG_GAIN_I: cfg.gain_i         = data[GAIN_W-1:0];
            REG_GAIN_D: cfg.gain_d         = data[GAIN_W-1:0];
            REG_LIMIT:  cfg.integral_limit = data[LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int spread(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Setup and access phases; the write lands on the access edge.
    task automatic write_reg(input int idx, input logic [APB_DW-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx * 4);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        shadow_reg(idx, data);
    endtask

    task automatic feed(input logic signed [DELTA_W-1:0] delta);
        pending_deltas.push_back(delta);
        deltas_in_flight++;
    endtask

    // Block is idle once every beat is taken and every result seen;
    // the extra cycles cover the sequencer finishing its last step.
    task automatic drain();
        while (deltas_in_flight != 0 || expected_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Random setup per phase, extremes weighted in. Full 32-bit data also
    // exercises the truncation of oversized writes.
    task automatic random_setup();
        logic [APB_DW-1:0] v;
        case ($urandom_range(3))
            0:       v = $urandom();
            1:       v = 32'h0000_7FFF;
            2:       v = 32'h0000_8000;
            default: v = spread(200);
        endcase
        write_reg(REG_TARGET, v);
        case ($urandom_range(3))
            0:       v = $urandom();
            1:       v = '0;
            2:       v = 32'h00FF_FFFF;
            default: v = 32'h0001_0000 + spread(4096);
        endcase
        write_reg(REG_SCALE, v);
        for (int r = REG_GAIN_P; r <= REG_GAIN_D; r++)
        begin
            case ($urandom_range(4))
                0:       v = $urandom();
                1:       v = 32'h0000_7FFF;
                2:       v = 32'h0000_8000;
                default: v = spread(512);
            endcase
            write_reg(r, v);
        end
        case ($urandom_range(3))
            0:       v = '0;
            1:       v = 32'h7FFF_FFFF;
            2:       v = $urandom();
            default: v = $urandom_range(1000);
        endcase
        write_reg(REG_LIMIT, v);
        if ($urandom_range(1) != 0)
            write_reg($urandom_range(REG_SPARE_HI, REG_SPARE_LO), $urandom());
    endtask

    // Driver: a new beat goes out only once the current one is taken, so
    // valid and payload hold steady under stall.
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (pending_deltas.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                in_valid      <= 1'b1;
                encoder_delta <= pending_deltas.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver backpressure.
    always @(posedge clk)
        out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);

    // Monitor: predict on every input beat taken, check every output beat
    // against the oldest prediction.
    always @(posedge clk)
    begin
        logic signed [DRIVE_W-1:0] want;
        if (rst_n && in_valid && !in_stall)
        begin
            expected_drive.push_back(step_controller(encoder_delta));
            deltas_in_flight--;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_drive.size() == 0)
            begin
                $display("%0t: drive_value expected none got %0d", $time, drive_value);
                mismatches++;
            end
            else
            begin
                want = expected_drive.pop_front();
                if (drive_value !== want)
                begin
                    $display("%0t: drive_value expected %0d got %0d",
                             $time, want, drive_value);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        cfg = '{target_speed: '0, count_scale: SCALE_RESET, gain_p: '0,
                gain_i: '0, gain_d: '0, integral_limit: LIMIT_RESET};
        prev_err = '0;
        integ    = '0;
        send_gap_pct   = 30;
        recv_stall_pct = 80;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: zero gains give zero drive
        feed(16'sd0);
        feed(16'sd32767);
        drain();

        // unity P, half I, negative D, tight clamp; D data has excess bits
        write_reg(REG_GAIN_P, 32'd256);
        write_reg(REG_GAIN_I, 32'd128);
        write_reg(REG_GAIN_D, 32'hFFFF_FF00);
        write_reg(REG_TARGET, 32'd100);
        write_reg(REG_LIMIT, 32'd50);
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        feed(16'sd0);       // integral hits the upper clamp
        feed(16'sd0);
        feed(16'sd100);     // zero error
        feed(16'sd32767);   // swings to the lower clamp
        feed(-16'sd32768);
        feed(-16'sd1);
        feed(16'sd1);
        feed(16'sd0);
        drain();

        // zero limit keeps the integral at zero
        write_reg(REG_LIMIT, 32'd0);
        write_reg(REG_SPARE_HI, 32'h8000_0001);
        feed(16'sd1);
        feed(-16'sd1);
        feed(16'sd50);
        drain();

        // extreme scale and gains: output saturates both ways
        write_reg(REG_TARGET, 32'h0000_8000);
        write_reg(REG_SCALE, 32'hFFFF_FFFF);
        write_reg(REG_GAIN_P, 32'h0000_7FFF);
        write_reg(REG_GAIN_I, 32'h0000_8000);
        write_reg(REG_GAIN_D, 32'h0000_7FFF);
        write_reg(REG_LIMIT, 32'hFFFF_FFFF);
        feed(16'sd32767);
        feed(-16'sd32768);
        feed(16'sd32767);
        feed(16'sd0);
        feed(-16'sd32768);
        drain();

        // random phases: sender-light/receiver-heavy, then the reverse,
        // then full rate with no gaps
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph < 4)
            begin
                send_gap_pct   = 30;
                recv_stall_pct = 80;
            end
            else if (ph < 8)
            begin
                send_gap_pct   = 80;
                recv_stall_pct = 30;
            end
            else
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            random_setup();
            // mostly small deltas so the loop settles and the clamp engages,
            // with full-range deltas mixed in
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if ($urandom_range(3) == 0)
                    feed(DELTA_W'($urandom()));
                else
                    feed(DELTA_W'(spread(64)));
            end
            drain();
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
